### rtl/core/gmg_pkg.sv
package gmg_pkg;

  // field widths fixed by the item format
  localparam int SIDE_W     = 9;
  localparam int LEN_W      = 16;
  localparam int COORD_W    = 17;
  localparam int TEX_W      = 16;
  localparam int VNUM_W     = 16;
  localparam int KIND_W     = 2;
  localparam int CORNER_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_SIDE_DEF = 256;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INDEX  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  // walk phases
  localparam logic [1:0] PH_VERTEX = 2'd0;
  localparam logic [1:0] PH_INDEX  = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_U = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_V = 3'd5;

  // register reset values
  localparam logic [SIDE_W-1:0] ROWS_RST  = 9'd2;
  localparam logic [SIDE_W-1:0] COLS_RST  = 9'd2;
  localparam logic [LEN_W-1:0]  WIDTH_RST = 16'd16;
  localparam logic [LEN_W-1:0]  DEPTH_RST = 16'd16;
  localparam logic [LEN_W-1:0]  TILE_RST  = 16'd256;

  // quotient selects
  localparam logic [1:0] DIV_X = 2'd0;
  localparam logic [1:0] DIV_Z = 2'd1;
  localparam logic [1:0] DIV_U = 2'd2;
  localparam logic [1:0] DIV_V = 2'd3;

  localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd5;

  typedef struct packed {
    logic       take;
    logic       div_go;
    logic       div_store;
    logic [1:0] sel;
    logic       emit;
  } gmg_cmd_t;

  typedef struct packed {
    logic vertex;
    logic div_done;
    logic out_free;
  } gmg_sts_t;

  // triangle corners of a quad: (0,0) (0,1) (1,0) (1,0) (0,1) (1,1)
  function automatic logic corner_dr(input logic [CORNER_W-1:0] q);
    logic d;
    case (q)
      3'd2, 3'd3, 3'd5: d = 1'b1;
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic corner_dc(input logic [CORNER_W-1:0] q);
    logic d;
    case (q)
      3'd1, 3'd4, 3'd5: d = 1'b1;
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/gmg_ifs.sv
interface gmg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface gmg_out_if;
  logic                                valid;
  logic                                ready;
  logic [gmg_pkg::KIND_W-1:0]          item_kind;
  logic signed [gmg_pkg::COORD_W-1:0]  pos_x;
  logic signed [gmg_pkg::COORD_W-1:0]  pos_z;
  logic [gmg_pkg::TEX_W-1:0]           tex_u;
  logic [gmg_pkg::TEX_W-1:0]           tex_v;
  logic [gmg_pkg::VNUM_W-1:0]          vertex_number;
  logic                                mesh_last;

  modport source (output valid, output item_kind, output pos_x, output pos_z,
                  output tex_u, output tex_v, output vertex_number,
                  output mesh_last, input ready);
  modport sink   (input valid, input item_kind, input pos_x, input pos_z,
                  input tex_u, input tex_v, input vertex_number,
                  input mesh_last, output ready);
endinterface

interface gmg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gmg_pkg::CFG_IDX_W-1:0]     index;
  logic [gmg_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/gmg_div.sv
module gmg_div #(
  parameter int NW = 25,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    den_r;
  logic [DW-1:0]    rem_r;
  logic [NW-1:0]    quo_r;

  logic [DW:0]      part;
  logic [DW:0]      diff;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign part = {rem_r, quo_r[NW-1]};
  assign diff = part - {1'b0, den_r};
  assign ge   = (part >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : part[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/core/gmg_dp.sv
module gmg_dp #(
  parameter int MAX_SIDE = gmg_pkg::MAX_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gmg_pkg::gmg_cmd_t                   cmd,
  output gmg_pkg::gmg_sts_t                   sts,
  input  logic                                restart,
  input  logic                                cfg_wr,
  input  logic [gmg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gmg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [gmg_pkg::KIND_W-1:0]          out_item_kind,
  output logic signed [gmg_pkg::COORD_W-1:0]  out_pos_x,
  output logic signed [gmg_pkg::COORD_W-1:0]  out_pos_z,
  output logic [gmg_pkg::TEX_W-1:0]           out_tex_u,
  output logic [gmg_pkg::TEX_W-1:0]           out_tex_v,
  output logic [gmg_pkg::VNUM_W-1:0]          out_vertex_number,
  output logic                                out_mesh_last
);

  localparam int SW = gmg_pkg::SIDE_W;
  localparam int LW = gmg_pkg::LEN_W;
  localparam int XW = gmg_pkg::COORD_W;
  localparam int TW = gmg_pkg::TEX_W;
  localparam int VW = gmg_pkg::VNUM_W;
  localparam int QW = gmg_pkg::CORNER_W;
  localparam int CW = $clog2(MAX_SIDE);
  localparam int NW = CW + LW + 1;
  localparam int PW = (2 * CW + 2 > VW) ? 2 * CW + 2 : VW;

  // configuration
  logic [SW-1:0] rows_r, cols_r;
  logic [LW-1:0] width_r, depth_r, tile_u_r, tile_v_r;

  // walk state
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [QW-1:0] q_r, q_nxt;

  // quotients
  logic [XW-1:0] qx_r, qz_r;
  logic [TW-1:0] qu_r, qv_r;

  // result word
  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic [XW-1:0]         out_px_r, out_pz_r;
  logic [TW-1:0]         out_tu_r, out_tv_r;
  logic [VW-1:0]         out_vnum_r;
  logic                  out_last_r;

  logic [SW-1:0] rows_lim, cols_lim;
  logic [CW-1:0] rows_m1, cols_m1, rows_m2, cols_m2;
  logic [CW:0]   cols_w;

  logic [1:0]    phase_src;
  logic [CW-1:0] r_src, c_src;
  logic [QW-1:0] q_src;

  logic [CW-1:0]    mul_a;
  logic [LW-1:0]    mul_b;
  logic [CW+LW-1:0] prod;
  logic [NW-1:0]    div_num;
  logic [CW-1:0]    div_den;
  logic             div_done;
  logic [NW-1:0]    div_quo;

  logic [CW:0]   vr, vc;
  logic [PW-1:0] vprod;
  logic          is_last;

  logic [1:0]    kind_nxt;
  logic [XW-1:0] px_nxt, pz_nxt;
  logic [TW-1:0] tu_nxt, tv_nxt;
  logic [VW-1:0] vnum_nxt;
  logic          last_nxt;

  // sides out of range are pinned to 2 and MAX_SIDE
  always_comb begin
    if (rows_r < SW'(2))             rows_lim = SW'(2);
    else if (rows_r > SW'(MAX_SIDE)) rows_lim = SW'(MAX_SIDE);
    else                             rows_lim = rows_r;
    if (cols_r < SW'(2))             cols_lim = SW'(2);
    else if (cols_r > SW'(MAX_SIDE)) cols_lim = SW'(MAX_SIDE);
    else                             cols_lim = cols_r;
  end

  assign rows_m1 = CW'(rows_lim - SW'(1));
  assign cols_m1 = CW'(cols_lim - SW'(1));
  assign rows_m2 = CW'(rows_lim - SW'(2));
  assign cols_m2 = CW'(cols_lim - SW'(2));
  assign cols_w  = (CW+1)'(cols_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= gmg_pkg::ROWS_RST;
      cols_r   <= gmg_pkg::COLS_RST;
      width_r  <= gmg_pkg::WIDTH_RST;
      depth_r  <= gmg_pkg::DEPTH_RST;
      tile_u_r <= gmg_pkg::TILE_RST;
      tile_v_r <= gmg_pkg::TILE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        gmg_pkg::REG_ROWS:   rows_r   <= cfg_data[SW-1:0];
        gmg_pkg::REG_COLS:   cols_r   <= cfg_data[SW-1:0];
        gmg_pkg::REG_WIDTH:  width_r  <= cfg_data[LW-1:0];
        gmg_pkg::REG_DEPTH:  depth_r  <= cfg_data[LW-1:0];
        gmg_pkg::REG_TILE_U: tile_u_r <= cfg_data[LW-1:0];
        gmg_pkg::REG_TILE_V: tile_v_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // counters are clamped to the current grid when a word is taken
  assign phase_src = restart ? gmg_pkg::PH_VERTEX : phase_r;
  assign r_src     = restart ? '0 : r_r;
  assign c_src     = restart ? '0 : c_r;
  assign q_src     = restart ? '0 : q_r;

  always_comb begin
    phase_nxt = phase_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    q_nxt     = q_r;
    if (cmd.take) begin
      phase_nxt = phase_src;
      r_nxt     = r_src;
      c_nxt     = c_src;
      q_nxt     = q_src;
      case (phase_src)
        gmg_pkg::PH_VERTEX: begin
          if (r_src > rows_m1) r_nxt = rows_m1;
          if (c_src > cols_m1) c_nxt = cols_m1;
        end
        gmg_pkg::PH_INDEX: begin
          if (r_src > rows_m2) r_nxt = rows_m2;
          if (c_src > cols_m2) c_nxt = cols_m2;
          if (q_src > gmg_pkg::CORNER_LAST) q_nxt = '0;
        end
        default: ;
      endcase
    end else if (cmd.emit) begin
      case (phase_r)
        gmg_pkg::PH_VERTEX: begin
          if (c_r == cols_m1) begin
            c_nxt = '0;
            if (r_r == rows_m1) begin
              r_nxt     = '0;
              q_nxt     = '0;
              phase_nxt = gmg_pkg::PH_INDEX;
            end else begin
              r_nxt = r_r + CW'(1);
            end
          end else begin
            c_nxt = c_r + CW'(1);
          end
        end
        gmg_pkg::PH_INDEX: begin
          if (q_r == gmg_pkg::CORNER_LAST) begin
            q_nxt = '0;
            if (c_r == cols_m2) begin
              c_nxt = '0;
              if (r_r == rows_m2) begin
                r_nxt     = '0;
                phase_nxt = gmg_pkg::PH_DONE;
              end else begin
                r_nxt = r_r + CW'(1);
              end
            end else begin
              c_nxt = c_r + CW'(1);
            end
          end else begin
            q_nxt = q_r + QW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gmg_pkg::PH_VERTEX;
      r_r     <= '0;
      c_r     <= '0;
      q_r     <= '0;
    end else begin
      phase_r <= phase_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      q_r     <= q_nxt;
    end
  end

  // dividend: counter times length, doubled for positions
  assign mul_a = (cmd.sel == gmg_pkg::DIV_X || cmd.sel == gmg_pkg::DIV_U) ? c_r : r_r;

  always_comb begin
    case (cmd.sel)
      gmg_pkg::DIV_X: mul_b = width_r;
      gmg_pkg::DIV_Z: mul_b = depth_r;
      gmg_pkg::DIV_U: mul_b = tile_u_r;
      default:        mul_b = tile_v_r;
    endcase
  end

  assign prod    = (CW+LW)'(mul_a * mul_b);
  assign div_num = (cmd.sel == gmg_pkg::DIV_X || cmd.sel == gmg_pkg::DIV_Z) ?
                   {prod, 1'b0} : {1'b0, prod};
  assign div_den = (cmd.sel == gmg_pkg::DIV_X || cmd.sel == gmg_pkg::DIV_U) ?
                   cols_m1 : rows_m1;

  gmg_div #(
    .NW (NW),
    .DW (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.sel)
        gmg_pkg::DIV_X: qx_r <= div_quo[XW-1:0];
        gmg_pkg::DIV_Z: qz_r <= div_quo[XW-1:0];
        gmg_pkg::DIV_U: qu_r <= div_quo[TW-1:0];
        default:        qv_r <= div_quo[TW-1:0];
      endcase
    end
  end

  // vertex number, or the corner of the current quad
  always_comb begin
    if (phase_r == gmg_pkg::PH_INDEX) begin
      vr = {1'b0, r_r} + (CW+1)'(gmg_pkg::corner_dr(q_r));
      vc = {1'b0, c_r} + (CW+1)'(gmg_pkg::corner_dc(q_r));
    end else begin
      vr = {1'b0, r_r};
      vc = {1'b0, c_r};
    end
  end

  assign vprod   = PW'(vr) * PW'(cols_w) + PW'(vc);
  assign is_last = (r_r == rows_m2) && (c_r == cols_m2) && (q_r == gmg_pkg::CORNER_LAST);

  always_comb begin
    kind_nxt = gmg_pkg::KIND_DONE;
    px_nxt   = '0;
    pz_nxt   = '0;
    tu_nxt   = '0;
    tv_nxt   = '0;
    vnum_nxt = '0;
    last_nxt = 1'b0;
    case (phase_r)
      gmg_pkg::PH_VERTEX: begin
        kind_nxt = gmg_pkg::KIND_VERTEX;
        px_nxt   = qx_r - {1'b0, width_r};
        pz_nxt   = {1'b0, depth_r} - qz_r;
        tu_nxt   = qu_r;
        tv_nxt   = qv_r;
        vnum_nxt = vprod[VW-1:0];
      end
      gmg_pkg::PH_INDEX: begin
        kind_nxt = gmg_pkg::KIND_INDEX;
        vnum_nxt = vprod[VW-1:0];
        last_nxt = is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | (out_valid_r & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= kind_nxt;
      out_px_r   <= px_nxt;
      out_pz_r   <= pz_nxt;
      out_tu_r   <= tu_nxt;
      out_tv_r   <= tv_nxt;
      out_vnum_r <= vnum_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign sts.vertex   = (phase_r == gmg_pkg::PH_VERTEX);
  assign sts.div_done = div_done;
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_kind_r;
  assign out_pos_x         = $signed(out_px_r);
  assign out_pos_z         = $signed(out_pz_r);
  assign out_tex_u         = out_tu_r;
  assign out_tex_v         = out_tv_r;
  assign out_vertex_number = out_vnum_r;
  assign out_mesh_last     = out_last_r;

  a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted word not held in result register");

  a_last_only_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != gmg_pkg::KIND_INDEX |-> !out_last_r)
    else $error("mesh_last on a word that is not an index");

  a_done_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == gmg_pkg::KIND_DONE |-> out_vnum_r == '0)
    else $error("finished word carries a vertex number");

  a_store_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_store |-> div_done)
    else $error("quotient stored before divider finished");

  a_take_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (phase_r != gmg_pkg::PH_VERTEX || (r_r <= rows_m1 && c_r <= cols_m1)))
    else $error("vertex counters outside the grid after take");

endmodule

### rtl/core/gmg_ctrl.sv
module gmg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  gmg_pkg::gmg_sts_t sts,
  output gmg_pkg::gmg_cmd_t cmd,
  output logic              in_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic [1:0] sel_r;
  logic       in_ready_r;

  always_comb begin
    cmd           = '0;
    cmd.sel       = sel_r;
    cmd.take      = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.div_go    = (state_r == S_START) && sts.vertex;
    cmd.div_store = (state_r == S_WAIT) && sts.div_done;
    cmd.emit      = (state_r == S_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      sel_r      <= gmg_pkg::DIV_X;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_START;
            sel_r      <= gmg_pkg::DIV_X;
            in_ready_r <= 1'b0;
          end
        end
        S_START: begin
          // index and finished words need no quotients
          if (sts.vertex) state_r <= S_WAIT;
          else            state_r <= S_EMIT;
        end
        S_WAIT: begin
          if (sts.div_done) begin
            if (sel_r == gmg_pkg::DIV_V) begin
              state_r <= S_EMIT;
            end else begin
              sel_r   <= sel_r + 2'd1;
              state_r <= S_START;
            end
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready = in_ready_r;

endmodule

### rtl/core/grid_mesh_generator.sv
// vertex word: result valid once four serial quotients have run through one shared
// bit-per-cycle divider
// index and finished words skip the divider and go straight to the result register
// one word in flight, the next taken once its result is registered
// rst_n (synchronous) restores the register defaults and restarts at the first vertex
module grid_mesh_generator #(
  parameter int MAX_SIDE = gmg_pkg::MAX_SIDE_DEF
) (
  input logic        clk,
  input logic        rst_n,
  gmg_in_if.sink     in_port,
  gmg_out_if.source  out_port,
  gmg_cfg_if.sink    cfg_port
);

  gmg_pkg::gmg_cmd_t cmd;
  gmg_pkg::gmg_sts_t sts;

  assign cfg_port.ready = 1'b1;

  gmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_port.valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_port.ready)
  );

  gmg_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .restart           (in_port.restart),
    .cfg_wr            (cfg_port.valid),
    .cfg_index         (cfg_port.index),
    .cfg_data          (cfg_port.data),
    .out_ready         (out_port.ready),
    .out_valid         (out_port.valid),
    .out_item_kind     (out_port.item_kind),
    .out_pos_x         (out_port.pos_x),
    .out_pos_z         (out_port.pos_z),
    .out_tex_u         (out_port.tex_u),
    .out_tex_v         (out_port.tex_v),
    .out_vertex_number (out_port.vertex_number),
    .out_mesh_last     (out_port.mesh_last)
  );

endmodule

### test/tb.sv
module tb;
  import gmg_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int RANDOM_WORDS = 500;

  // register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  // triangle corners of a quad, bit q is the row or column step of corner q
  localparam bit [5:0] CORNER_ROW_STEP = 6'b101100;
  localparam bit [5:0] CORNER_COL_STEP = 6'b110010;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] pz;
    logic [TEX_W-1:0]          tu;
    logic [TEX_W-1:0]          tv;
    logic [VNUM_W-1:0]         vnum;
    logic                      last;
  } mesh_word_t;

  typedef struct {
    bit                      is_reg;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    bit                      rs;
    bit                      typed;
    mesh_word_t              want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  gmg_in_if  in_if ();
  gmg_out_if out_if ();
  gmg_cfg_if cfg_if ();

  grid_mesh_generator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if),
    .cfg_port (cfg_if)
  );

  // mirror of the generator
  logic [SIDE_W-1:0] reg_rows, reg_cols;
  logic [LEN_W-1:0]  reg_width, reg_depth, reg_tile_u, reg_tile_v;
  logic [1:0]        walk_phase;
  int unsigned       walk_row, walk_col, walk_corner;

  mesh_word_t mesh_words_due[$];
  plan_row_t  plan[$];
  int         fails = 0;
  int         cycles = 0;
  bit         steady;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned side_of(input logic [SIDE_W-1:0] s);
    if (s < 2) return 2;
    if (s > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return 32'(s);
  endfunction

  function automatic mesh_word_t next_mesh_word(input bit rs);
    mesh_word_t  w;
    int unsigned nr, nc, r, c, q, qx, qz, tu, tv, idx;
    int          sx, sz;
    nr = side_of(reg_rows);
    nc = side_of(reg_cols);
    w = '0;
    if (rs) begin
      walk_phase = PH_VERTEX;
      walk_row = 0;
      walk_col = 0;
      walk_corner = 0;
    end
    case (walk_phase)
      PH_VERTEX: begin
        if (walk_row > nr - 1) walk_row = nr - 1;
        if (walk_col > nc - 1) walk_col = nc - 1;
        r = walk_row;
        c = walk_col;
        qx = (32'd2 * c * reg_width) / (nc - 1);
        qz = (32'd2 * r * reg_depth) / (nr - 1);
        sx = int'(qx) - int'(reg_width);
        sz = int'(reg_depth) - int'(qz);
        tu = (c * reg_tile_u) / (nc - 1);
        tv = (r * reg_tile_v) / (nr - 1);
        idx = r * nc + c;
        w.kind = KIND_VERTEX;
        w.px = sx[COORD_W-1:0];
        w.pz = sz[COORD_W-1:0];
        w.tu = tu[TEX_W-1:0];
        w.tv = tv[TEX_W-1:0];
        w.vnum = idx[VNUM_W-1:0];
        walk_col = c + 1;
        if (walk_col >= nc) begin
          walk_col = 0;
          walk_row = r + 1;
          if (walk_row >= nr) begin
            walk_row = 0;
            walk_corner = 0;
            walk_phase = PH_INDEX;
          end
        end
      end
      PH_INDEX: begin
        if (walk_row > nr - 2) walk_row = nr - 2;
        if (walk_col > nc - 2) walk_col = nc - 2;
        if (walk_corner > CORNER_LAST) walk_corner = 0;
        r = walk_row;
        c = walk_col;
        q = walk_corner;
        idx = (r + CORNER_ROW_STEP[q]) * nc + c + CORNER_COL_STEP[q];
        w.kind = KIND_INDEX;
        w.vnum = idx[VNUM_W-1:0];
        w.last = (r == nr - 2) && (c == nc - 2) && (q == CORNER_LAST);
        walk_corner = q + 1;
        if (walk_corner > CORNER_LAST) begin
          walk_corner = 0;
          walk_col = c + 1;
          if (walk_col >= nc - 1) begin
            walk_col = 0;
            walk_row = r + 1;
            if (walk_row >= nr - 1) begin
              walk_row = 0;
              walk_phase = PH_DONE;
            end
          end
        end
      end
      default: w.kind = KIND_DONE;
    endcase
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    logic [CFG_DATA_W-1:0] s;
    case ($urandom_range(0, 15))
      0: s = 16'($urandom_range(0, 1));
      1: s = {7'($urandom), 9'($urandom_range(2, 5))};
      default: s = 16'($urandom_range(2, 5));
    endcase
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_len();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic mesh_word_t vertex_at(input int x, input int z, input int u,
                                           input int v, input int n);
    mesh_word_t w;
    w = '0;
    w.kind = KIND_VERTEX;
    w.px = x[COORD_W-1:0];
    w.pz = z[COORD_W-1:0];
    w.tu = u[TEX_W-1:0];
    w.tv = v[TEX_W-1:0];
    w.vnum = n[VNUM_W-1:0];
    return w;
  endfunction

  function automatic mesh_word_t index_at(input int n, input bit last);
    mesh_word_t w;
    w = '0;
    w.kind = KIND_INDEX;
    w.vnum = n[VNUM_W-1:0];
    w.last = last;
    return w;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t p;
    p = '{default: '0};
    p.is_reg = 1'b1;
    p.idx = idx;
    p.data = data;
    return p;
  endfunction

  function automatic plan_row_t word_row(input bit rs);
    plan_row_t p;
    p = '{default: '0};
    p.rs = rs;
    return p;
  endfunction

  function automatic plan_row_t typed_row(input bit rs, input mesh_word_t want);
    plan_row_t p;
    p = '{default: '0};
    p.rs = rs;
    p.typed = 1'b1;
    p.want = want;
    return p;
  endfunction

  task automatic add_plan(input plan_row_t p);
    plan.insert(plan.size(), p);
  endtask

  task automatic send_word(input bit rs, input bit typed, input mesh_word_t want);
    mesh_word_t  pred;
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.restart <= rs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred = next_mesh_word(rs);
    mesh_words_due.insert(mesh_words_due.size(), typed ? want : pred);
    gap = (steady || $urandom_range(0, 1)) ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the input side until every word in flight has come out
  task automatic quiesce();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (mesh_words_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_ROWS:   reg_rows = data[SIDE_W-1:0];
      REG_COLS:   reg_cols = data[SIDE_W-1:0];
      REG_WIDTH:  reg_width = data;
      REG_DEPTH:  reg_depth = data;
      REG_TILE_U: reg_tile_u = data;
      REG_TILE_V: reg_tile_v = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random back-pressure and the word check
  always @(posedge clk) begin : take_words
    mesh_word_t due;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (mesh_words_due.size() == 0) begin
        $error("word with nothing expected: kind %0d", out_if.item_kind);
        fails++;
      end else begin
        due = mesh_words_due.pop_front();
        if (out_if.item_kind !== due.kind) begin
          $error("item_kind: expected %0d, got %0d", due.kind, out_if.item_kind);
          fails++;
        end
        if (out_if.pos_x !== due.px) begin
          $error("pos_x: expected %0d, got %0d", due.px, out_if.pos_x);
          fails++;
        end
        if (out_if.pos_z !== due.pz) begin
          $error("pos_z: expected %0d, got %0d", due.pz, out_if.pos_z);
          fails++;
        end
        if (out_if.tex_u !== due.tu) begin
          $error("tex_u: expected %0d, got %0d", due.tu, out_if.tex_u);
          fails++;
        end
        if (out_if.tex_v !== due.tv) begin
          $error("tex_v: expected %0d, got %0d", due.tv, out_if.tex_v);
          fails++;
        end
        if (out_if.vertex_number !== due.vnum) begin
          $error("vertex_number: expected %0d, got %0d", due.vnum, out_if.vertex_number);
          fails++;
        end
        if (out_if.mesh_last !== due.last) begin
          $error("mesh_last: expected %0d, got %0d", due.last, out_if.mesh_last);
          fails++;
        end
      end
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned n_rand, walk_len, nr, nc, k, variant;
    logic [CFG_DATA_W-1:0] rows_data, cols_data;

    steady = 1'b0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.restart <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_ROWS;
    cfg_if.data <= '0;

    reg_rows = ROWS_RST;
    reg_cols = COLS_RST;
    reg_width = WIDTH_RST;
    reg_depth = DEPTH_RST;
    reg_tile_u = TILE_RST;
    reg_tile_v = TILE_RST;
    walk_phase = PH_VERTEX;
    walk_row = 0;
    walk_col = 0;
    walk_corner = 0;

    // default 2x2 grid straight out of reset
    add_plan(typed_row(1'b0, vertex_at(-16, 16, 0, 0, 0)));
    add_plan(typed_row(1'b0, vertex_at(16, 16, 256, 0, 1)));
    add_plan(typed_row(1'b0, vertex_at(-16, -16, 0, 256, 2)));
    add_plan(typed_row(1'b0, vertex_at(16, -16, 256, 256, 3)));
    add_plan(typed_row(1'b0, index_at(0, 1'b0)));
    add_plan(typed_row(1'b0, index_at(1, 1'b0)));
    add_plan(typed_row(1'b0, index_at(2, 1'b0)));
    add_plan(typed_row(1'b0, index_at(2, 1'b0)));
    add_plan(typed_row(1'b0, index_at(1, 1'b0)));
    add_plan(typed_row(1'b0, index_at(3, 1'b1)));
    add_plan(typed_row(1'b0, '{KIND_DONE, 17'sd0, 17'sd0, 16'd0, 16'd0, 16'd0, 1'b0}));
    add_plan(typed_row(1'b0, '{KIND_DONE, 17'sd0, 17'sd0, 16'd0, 16'd0, 16'd0, 1'b0}));
    add_plan(typed_row(1'b1, vertex_at(-16, 16, 0, 0, 0)));
    // sides below range, full-scale lengths and tiling
    add_plan(reg_row(REG_ROWS, 16'h0001));
    add_plan(reg_row(REG_COLS, 16'h0000));
    add_plan(reg_row(REG_WIDTH, 16'hFFFF));
    add_plan(reg_row(REG_DEPTH, 16'hFFFF));
    add_plan(reg_row(REG_TILE_U, 16'hFFFF));
    add_plan(reg_row(REG_TILE_V, 16'hFFFF));
    add_plan(typed_row(1'b1, vertex_at(-65535, 65535, 0, 0, 0)));
    add_plan(typed_row(1'b0, vertex_at(65535, 65535, 65535, 0, 1)));
    add_plan(word_row(1'b0));
    // sides above range, changed part way through the vertices
    add_plan(reg_row(REG_COLS, 16'hFFFF));
    add_plan(word_row(1'b0));
    add_plan(reg_row(REG_ROWS, 16'h0101));
    add_plan(word_row(1'b0));
    add_plan(reg_row(REG_UNUSED_A, 16'hA5A5));
    add_plan(reg_row(REG_UNUSED_B, 16'h5A5A));
    // zero size, then a wider grid part way through the indices
    add_plan(reg_row(REG_WIDTH, 16'h0000));
    add_plan(reg_row(REG_DEPTH, 16'h0000));
    add_plan(reg_row(REG_ROWS, 16'h0002));
    add_plan(reg_row(REG_COLS, 16'h0002));
    add_plan(typed_row(1'b1, vertex_at(0, 0, 0, 0, 0)));
    for (int i = 0; i < 4; i++) add_plan(word_row(1'b0));
    add_plan(reg_row(REG_COLS, 16'h0003));
    for (int i = 0; i < 2; i++) add_plan(word_row(1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].rs, plan[i].typed, plan[i].want);
      end
    end

    n_rand = 0;
    while (n_rand < RANDOM_WORDS) begin
      quiesce();
      steady = ($urandom_range(0, 4) == 0);
      variant = $urandom_range(0, 9);
      if (variant <= 5) begin
        // whole small mesh from a restart, now and then broken by another
        rows_data = pick_side();
        cols_data = pick_side();
        write_reg(REG_ROWS, rows_data);
        write_reg(REG_COLS, cols_data);
        write_reg(REG_WIDTH, pick_len());
        write_reg(REG_DEPTH, pick_len());
        write_reg(REG_TILE_U, pick_len());
        write_reg(REG_TILE_V, pick_len());
        nr = side_of(rows_data[SIDE_W-1:0]);
        nc = side_of(cols_data[SIDE_W-1:0]);
        walk_len = nr * nc + 6 * (nr - 1) * (nc - 1) + $urandom_range(1, 3);
        send_word(1'b1, 1'b0, '0);
        for (k = 1; k < walk_len; k++) send_word($urandom_range(0, 59) == 0, 1'b0, '0);
      end else if (variant == 6) begin
        // big grid, only the start of the walk
        write_reg(REG_ROWS, 16'($urandom));
        write_reg(REG_COLS, 16'($urandom));
        write_reg(REG_WIDTH, pick_len());
        write_reg(REG_DEPTH, pick_len());
        send_word(1'b1, 1'b0, '0);
        walk_len = $urandom_range(20, 40);
      end else if (variant == 7) begin
        // resize where the walk stands
        write_reg($urandom_range(0, 1) ? REG_ROWS : REG_COLS, pick_side());
        walk_len = $urandom_range(5, 30);
      end else if (variant == 8) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, 16'($urandom));
        write_reg($urandom_range(0, 1) ? REG_TILE_U : REG_TILE_V, pick_len());
        walk_len = $urandom_range(5, 20);
      end else begin
        for (k = 0; k < $urandom_range(5, 10); k++) begin
          send_word($urandom_range(0, 1), 1'b0, '0);
          n_rand++;
        end
        walk_len = 0;
      end
      if (variant <= 5) begin
        n_rand += walk_len;
      end else begin
        for (k = 0; k < walk_len; k++) begin
          send_word(1'b0, 1'b0, '0);
          n_rand++;
        end
      end
    end

    quiesce();
    repeat (120) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
rtl/core/gmg_pkg.sv
rtl/core/gmg_ifs.sv
rtl/core/gmg_div.sv
rtl/core/gmg_dp.sv
rtl/core/gmg_ctrl.sv
rtl/core/grid_mesh_generator.sv
test/tb.sv
